/* rtl/core/nalsplit_pkg.sv */
// nalsplit_pkg: shared constants and the unit record type of the annex b nal splitter
// depends on nothing; used by every module under rtl/core
package nalsplit_pkg;

  // default scan window and register reset
  localparam int          BUFFER_BYTES_DEFAULT = 65536;
  localparam logic [7:0]  MAX_UNITS_RESET      = 8'd100;

  // field widths of one result word
  localparam int OFFSET_W   = 16;
  localparam int LENGTH_W   = 17;
  localparam int TYPE_W     = 5;
  localparam int OUT_DATA_W = 40;

  // start code marker and empty byte history
  localparam logic [7:0]  START_MARK    = 8'h01;
  localparam logic [23:0] HISTORY_RESET = 24'hFFFFFF;

  // queue between scanner and output stage, power of two
  localparam int QUEUE_DEPTH = 4;

  // one finished unit, positions kept modulo 2^LENGTH_W
  typedef struct packed {
    logic [LENGTH_W-1:0] start;
    logic [LENGTH_W-1:0] stop;
    logic [TYPE_W-1:0]   nal_type;
    logic                final_unit;
    logic                capped;
  } unit_rec_t;

endpackage

/* rtl/core/annexb_nal_unit_splitter_unit.sv */
// annexb_nal_unit_splitter_unit: top level of the annex b start code nal splitter
// depends on nalsplit_pkg, nalsplit_front, nalsplit_queue, nalsplit_back
//
//   channel   direction  handshake             payload
//   cfg       in         cfg_wr_en             cfg_wr_data = max_units
//   s_axis    in         tvalid / tready       tdata = in_byte, tlast = last_byte
//   m_axis    out        tvalid / tready       tdata = offset, length, type;
//                                              tlast = last_unit, tuser = limit_hit
//
// one byte is taken per cycle while the queue has room; the scanner closes units
// in the cycle it arrives. result words are registered from the four-entry queue.
// s_axis_tready drops only when the queue is full, so output stalls reach the input
// after five pending units, four queued and one in the output register.
// rst is synchronous and clears all scan and queue state; max_units returns to 100.
module annexb_nal_unit_splitter_unit #(
  parameter int BUFFER_BYTES = nalsplit_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [nalsplit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [15:0] unit_offset, [32:16] unit_length, [37:33] unit_type, [39:38] zero
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] limit_hit
);
  import nalsplit_pkg::*;

  logic      queue_full;
  logic      push;
  unit_rec_t push_rec;
  logic      pop;
  logic      q_not_empty;
  unit_rec_t q_rec;

  // scanner
  nalsplit_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .last_byte  (s_axis_tlast),
    .queue_full (queue_full),
    .rec_valid  (push),
    .rec        (push_rec)
  );

  // record queue
  nalsplit_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (queue_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .pop_rec  (q_rec)
  );

  // output stage
  nalsplit_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rec_valid    (q_not_empty),
    .rec          (q_rec),
    .pop          (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

/* rtl/core/nalsplit_front.sv */
// nalsplit_front: byte scanner that finds start codes and closes units
// depends on nalsplit_pkg; feeds unit records into nalsplit_queue
module nalsplit_front #(
  parameter int BUFFER_BYTES = nalsplit_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  last_byte,
  input  logic                  queue_full,
  output logic                  rec_valid,
  output nalsplit_pkg::unit_rec_t rec
);
  import nalsplit_pkg::*;

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);

  typedef enum logic [1:0] {
    SEARCH = 2'd0,
    HEADER = 2'd1,
    INSIDE = 2'd2
  } phase_t;

  phase_t            phase, phase_next;
  logic [23:0]       history, history_next;
  logic [POS_W-1:0]  position, position_next;
  logic [POS_W-1:0]  unit_start, unit_start_next;
  logic [TYPE_W-1:0] current_type, current_type_next;
  logic [7:0]        units_reported, units_reported_next;
  logic [7:0]        max_units;

  logic              accept;
  logic              halted;
  logic              over;
  logic [23:0]       shifted;
  logic [7:0]        units_inc;
  logic              emit;
  logic [POS_W-1:0]  emit_start;
  logic [POS_W-1:0]  emit_stop;
  logic [TYPE_W-1:0] emit_type;
  logic              emit_final;
  logic              emit_capped;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // scan one byte, then close the open unit on the buffer end
  always_comb begin
    halted              = units_reported >= max_units;
    over                = position >= POS_W'(BUFFER_BYTES);
    shifted             = {history[15:0], in_byte};
    phase_next          = phase;
    history_next        = history;
    position_next       = position;
    unit_start_next     = unit_start;
    current_type_next   = current_type;
    units_reported_next = units_reported;
    units_inc           = units_reported + 8'd1;
    emit                = 1'b0;
    emit_start          = unit_start;
    emit_stop           = position;
    emit_type           = current_type;
    emit_final          = 1'b0;
    emit_capped         = 1'b0;
    if (accept) begin
      if (!halted && !over) begin
        history_next  = shifted;
        position_next = position + POS_W'(1);
        unique case (phase)
          HEADER: begin
            current_type_next = in_byte[TYPE_W-1:0];
            phase_next        = INSIDE;
            history_next      = HISTORY_RESET;
          end
          INSIDE: begin
            if (shifted == 24'd0 || shifted == {16'd0, START_MARK}) begin
              emit       = 1'b1;
              emit_stop  = position - POS_W'(2);
              emit_final = last_byte;
              if (shifted[7:0] == START_MARK) begin
                unit_start_next = position - POS_W'(2);
                phase_next      = HEADER;
              end else begin
                phase_next = SEARCH;
              end
            end
          end
          default: begin
            phase_next = SEARCH;
            if (in_byte == START_MARK && shifted[23:8] == 16'd0) begin
              if (shifted[23:16] == 8'd0 && position >= POS_W'(3)) begin
                unit_start_next = position - POS_W'(3);
              end else begin
                unit_start_next = position - POS_W'(2);
              end
              phase_next = HEADER;
            end
          end
        endcase
      end
      // open unit ends with the buffer
      if (last_byte && !emit && phase_next == INSIDE && !halted) begin
        emit       = 1'b1;
        emit_start = unit_start_next;
        emit_stop  = position_next;
        emit_type  = current_type_next;
        emit_final = 1'b1;
      end
      if (emit) begin
        emit_capped         = units_inc >= max_units;
        units_reported_next = units_inc;
      end
      // every buffer starts from a clean slate
      if (last_byte) begin
        phase_next          = SEARCH;
        history_next        = HISTORY_RESET;
        position_next       = '0;
        unit_start_next     = '0;
        current_type_next   = '0;
        units_reported_next = '0;
      end
    end
  end

  assign rec_valid      = emit;
  assign rec.start      = LENGTH_W'(emit_start);
  assign rec.stop       = LENGTH_W'(emit_stop);
  assign rec.nal_type   = emit_type;
  assign rec.final_unit = emit_final || emit_capped;
  assign rec.capped     = emit_capped;

  // scanner state and unit cap register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= SEARCH;
      history        <= HISTORY_RESET;
      position       <= '0;
      unit_start     <= '0;
      current_type   <= '0;
      units_reported <= '0;
      max_units      <= MAX_UNITS_RESET;
    end else begin
      phase          <= phase_next;
      history        <= history_next;
      position       <= position_next;
      unit_start     <= unit_start_next;
      current_type   <= current_type_next;
      units_reported <= units_reported_next;
      if (cfg_wr_en) begin
        max_units <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_buffer_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> position == '0 && units_reported == '0)
    else $error("scanner state not cleared after buffer end");
  a_cap_halts: assert property (@(posedge clk) disable iff (rst)
    emit && emit_capped && !last_byte && !cfg_wr_en |=> halted)
    else $error("scanner kept going after the unit cap");
  a_emit_needs_accept: assert property (@(posedge clk) disable iff (rst)
    emit |-> accept && !queue_full)
    else $error("unit record raised without an accepted byte");
`endif

endmodule

/* rtl/core/nalsplit_queue.sv */
// nalsplit_queue: short fifo of unit records between scanner and output stage
// depends on nalsplit_pkg
module nalsplit_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  nalsplit_pkg::unit_rec_t push_rec,
  output logic                    full,
  input  logic                    pop,
  output logic                    not_empty,
  output nalsplit_pkg::unit_rec_t pop_rec
);
  import nalsplit_pkg::*;

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  unit_rec_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;

  assign full      = count == COUNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_rec   = entries[rd_ptr];

  // record storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(QUEUE_DEPTH))
    else $error("queue fill level out of range");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + COUNT_W'(1))
    else $error("queue lost a record");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");
`endif

endmodule

/* rtl/core/nalsplit_back.sv */
// nalsplit_back: output register that turns unit records into result words
// depends on nalsplit_pkg; drains nalsplit_queue
module nalsplit_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rec_valid,
  input  nalsplit_pkg::unit_rec_t      rec,
  output logic                         pop,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [nalsplit_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                         m_axis_tlast,
  output logic                         m_axis_tuser
);
  import nalsplit_pkg::*;

  localparam int PAD_W = OUT_DATA_W - OFFSET_W - LENGTH_W - TYPE_W;

  logic                load;
  logic [LENGTH_W-1:0] unit_length;

  assign load        = rec_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop         = load;
  assign unit_length = rec.stop - rec.start;

  // result word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, rec.nal_type, unit_length, rec.start[OFFSET_W-1:0]};
      m_axis_tlast <= rec.final_unit;
      m_axis_tuser <= rec.capped;
    end
  end

`ifndef SYNTHESIS
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> m_axis_tvalid)
    else $error("loaded result word not presented");
  a_pop_only_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> rec_valid)
    else $error("output stage took a record that was not there");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result word changed while stalled");
`endif

endmodule
